// File: rtl/pta_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package pta_pkg;

  // Address geometry
  localparam int unsigned LOGICAL_ADDR_BITS  = 16;
  localparam int unsigned PHYSICAL_ADDR_BITS = 16;
  localparam int unsigned OFFSET_BITS        = 8;

  // Fixed port widths
  localparam int unsigned LA_W    = 16;
  localparam int unsigned PA_W    = 16;
  localparam int unsigned PN_W    = 8;
  localparam int unsigned FN_W    = 8;
  localparam int unsigned MAX_IDX = 8;

  // Page and frame index widths, capped at MAX_IDX bits
  localparam int unsigned PAGE_RAW  = (LOGICAL_ADDR_BITS > OFFSET_BITS) ?
                                      LOGICAL_ADDR_BITS - OFFSET_BITS : 0;
  localparam int unsigned FRAME_RAW = (PHYSICAL_ADDR_BITS > OFFSET_BITS) ?
                                      PHYSICAL_ADDR_BITS - OFFSET_BITS : 0;
  localparam int unsigned PAGE_BITS   = (PAGE_RAW > MAX_IDX) ? MAX_IDX : PAGE_RAW;
  localparam int unsigned FRAME_BITS  = (FRAME_RAW > MAX_IDX) ? MAX_IDX : FRAME_RAW;
  localparam int unsigned PAGE_COUNT  = 1 << PAGE_BITS;
  localparam int unsigned FRAME_COUNT = 1 << FRAME_BITS;
  localparam int unsigned FCNT_W      = FRAME_BITS + 1;

  // Address masks
  localparam logic [LA_W-1:0] LA_MASK = (LOGICAL_ADDR_BITS >= LA_W) ? {LA_W{1'b1}} :
                                        LA_W'((32'd1 << LOGICAL_ADDR_BITS) - 32'd1);
  localparam logic [PA_W-1:0] PA_MASK = (PHYSICAL_ADDR_BITS >= PA_W) ? {PA_W{1'b1}} :
                                        PA_W'((32'd1 << PHYSICAL_ADDR_BITS) - 32'd1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOK,
    ST_DONE
  } state_e;

  // Controller to datapath
  typedef struct packed {
    logic capture;  // take the incoming word
    logic look;     // read page table, decide hit or fault
    logic alloc;    // map the page to the next free frame
    logic load;     // move the result into the output register
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic hit;      // page currently mapped
    logic full;     // no free frame left
  } sts_t;

endpackage

`default_nettype wire

// File: rtl/page_translate_alloc.sv
`timescale 1ns / 1ps
`default_nettype none

// Demand-paging translator. Each input word is a logical address; the page
// number above the offset bits is looked up in a page table with per-page
// valid bits. On a miss the page is mapped to the lowest free physical frame
// and page_fault is set; when no frame is left out_of_frames is set, the page
// stays unmapped and the physical address and frame read as 0. All mappings
// are cleared by reset, with no clearing pass. Each item passes through
// accept, page table read (with allocation on a fault), and the load into the
// output register, which may hold one finished word while the next address is
// accepted. The single-port page table read sets the lookup step.
module page_translate_alloc (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      in_valid_i,
  output logic                           in_ready_o,
  input  wire logic [pta_pkg::LA_W-1:0]  logical_address_i,
  output logic                           out_valid_o,
  input  wire logic                      out_ready_i,
  output logic      [pta_pkg::PA_W-1:0]  physical_address_o,
  output logic      [pta_pkg::PN_W-1:0]  page_number_o,
  output logic      [pta_pkg::FN_W-1:0]  frame_number_o,
  output logic                           page_fault_o,
  output logic                           out_of_frames_o
);

  pta_pkg::cmd_t cmd;
  pta_pkg::sts_t sts;

  pta_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  pta_dp u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .sts_o              (sts),
    .logical_address_i  (logical_address_i),
    .physical_address_o (physical_address_o),
    .page_number_o      (page_number_o),
    .frame_number_o     (frame_number_o),
    .page_fault_o       (page_fault_o),
    .out_of_frames_o    (out_of_frames_o)
  );

endmodule

`default_nettype wire

// File: rtl/pta_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module pta_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  input  wire pta_pkg::sts_t sts_i,
  output pta_pkg::cmd_t      cmd_o
);

  pta_pkg::state_e state_q, state_d;
  logic            out_valid_q, out_valid_d;

  // State and output-valid registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= pta_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      pta_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = pta_pkg::ST_LOOK;
        end
      end
      pta_pkg::ST_LOOK: begin
        cmd_o.look  = 1'b1;
        cmd_o.alloc = !sts_i.hit && !sts_i.full;
        state_d     = pta_pkg::ST_DONE;
      end
      pta_pkg::ST_DONE: begin
        // wait for the output register to free up
        if (!out_valid_q || out_ready_i) begin
          cmd_o.load  = 1'b1;
          out_valid_d = 1'b1;
          state_d     = pta_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = pta_pkg::ST_IDLE;
      end
    endcase
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

// File: rtl/pta_dp.sv
`timescale 1ns / 1ps
`default_nettype none

module pta_dp (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire pta_pkg::cmd_t             cmd_i,
  output pta_pkg::sts_t                  sts_o,
  input  wire logic [pta_pkg::LA_W-1:0]  logical_address_i,
  output logic      [pta_pkg::PA_W-1:0]  physical_address_o,
  output logic      [pta_pkg::PN_W-1:0]  page_number_o,
  output logic      [pta_pkg::FN_W-1:0]  frame_number_o,
  output logic                           page_fault_o,
  output logic                           out_of_frames_o
);

  logic [pta_pkg::LA_W-1:0]        addr_m;
  logic [pta_pkg::PAGE_BITS-1:0]   page_q;
  logic [pta_pkg::OFFSET_BITS-1:0] offset_q;

  logic [pta_pkg::PAGE_COUNT-1:0]  page_valid_q;
  logic [pta_pkg::FCNT_W-1:0]      fcnt_q;

  logic [pta_pkg::FRAME_BITS-1:0]  mem [pta_pkg::PAGE_COUNT];
  logic [pta_pkg::FRAME_BITS-1:0]  rd_q;
  logic [pta_pkg::FRAME_BITS-1:0]  alloc_q;
  logic                            fault_q;
  logic                            oof_q;

  logic [pta_pkg::FRAME_BITS-1:0]  frame;
  logic [31:0]                     phys_wide;

  logic [pta_pkg::PA_W-1:0]        phys_q;
  logic [pta_pkg::PN_W-1:0]        pn_q;
  logic [pta_pkg::FN_W-1:0]        fn_q;
  logic                            pf_q;
  logic                            oofo_q;

  // Split the address into page and offset
  assign addr_m = logical_address_i & pta_pkg::LA_MASK;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      page_q   <= pta_pkg::PAGE_BITS'(addr_m >> pta_pkg::OFFSET_BITS);
      offset_q <= pta_pkg::OFFSET_BITS'(addr_m);
    end
  end

  // Frames are handed out lowest first and never returned, so the used set
  // is always a prefix and one fill count tracks it
  assign sts_o.hit  = page_valid_q[page_q];
  assign sts_o.full = (fcnt_q == pta_pkg::FCNT_W'(pta_pkg::FRAME_COUNT));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      page_valid_q <= '0;
      fcnt_q       <= '0;
    end else if (cmd_i.alloc) begin
      page_valid_q[page_q] <= 1'b1;
      fcnt_q               <= fcnt_q + pta_pkg::FCNT_W'(1);
    end
  end

  // Page table memory
  always_ff @(posedge clk_i) begin
    if (cmd_i.alloc) begin
      mem[page_q] <= fcnt_q[pta_pkg::FRAME_BITS-1:0];
    end
    if (cmd_i.look) begin
      rd_q <= mem[page_q];
    end
  end

  // Lookup outcome
  always_ff @(posedge clk_i) begin
    if (cmd_i.look) begin
      fault_q <= !sts_o.hit;
      oof_q   <= !sts_o.hit && sts_o.full;
      alloc_q <= fcnt_q[pta_pkg::FRAME_BITS-1:0];
    end
  end

  // Compose the physical address
  always_comb begin
    if (oof_q) begin
      frame = '0;
    end else if (fault_q) begin
      frame = alloc_q;
    end else begin
      frame = rd_q;
    end
    phys_wide = (32'(frame) << pta_pkg::OFFSET_BITS) | 32'(offset_q);
  end

  // Output register
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      phys_q <= oof_q ? '0 : (pta_pkg::PA_W'(phys_wide) & pta_pkg::PA_MASK);
      pn_q   <= pta_pkg::PN_W'(page_q);
      fn_q   <= pta_pkg::FN_W'(frame);
      pf_q   <= fault_q;
      oofo_q <= oof_q;
    end
  end

  assign physical_address_o = phys_q;
  assign page_number_o      = pn_q;
  assign frame_number_o     = fn_q;
  assign page_fault_o       = pf_q;
  assign out_of_frames_o    = oofo_q;

endmodule

`default_nettype wire

// File: dv/tb_page_translate_alloc.sv
`timescale 1ns / 1ps

module tb_page_translate_alloc;

  // One translation as seen on the result port
  typedef struct packed {
    logic [pta_pkg::PA_W-1:0] phys;
    logic [pta_pkg::PN_W-1:0] page;
    logic [pta_pkg::FN_W-1:0] frame;
    logic                     fault;
    logic                     no_frame;
  } xlate_t;

  // Page table model plus the queue of translations still owed by the block
  class xlate_scoreboard;
    logic [pta_pkg::FN_W-1:0] frame_of_page [256];
    bit                       page_mapped   [256];
    bit                       frame_claimed [256];
    xlate_t                   owed_xlate_q  [$];
    int                       errors;

    function new();
      for (int i = 0; i < 256; i++) begin
        frame_of_page[i] = '0;
        page_mapped[i]   = 1'b0;
        frame_claimed[i] = 1'b0;
      end
      errors = 0;
    endfunction

    // Translate one accepted address and update the tables
    function void note_address(logic [pta_pkg::LA_W-1:0] la);
      int unsigned addr;
      int unsigned page;
      int unsigned offs;
      int unsigned frame;
      xlate_t      x;
      addr  = 32'(la & pta_pkg::LA_MASK);
      page  = (pta_pkg::OFFSET_BITS < 32) ? (addr >> pta_pkg::OFFSET_BITS) : 0;
      page  = page & (pta_pkg::PAGE_COUNT - 1) & 32'hFF;
      offs  = addr & ((32'd1 << pta_pkg::OFFSET_BITS) - 32'd1);
      frame = 0;
      x     = '0;
      x.page = pta_pkg::PN_W'(page);
      // miss: claim the lowest free frame, or run dry
      if (!page_mapped[page]) begin
        x.fault    = 1'b1;
        x.no_frame = 1'b1;
        for (int i = 0; i < pta_pkg::FRAME_COUNT && i < 256; i++) begin
          if (!frame_claimed[i]) begin
            frame_claimed[i]    = 1'b1;
            frame_of_page[page] = pta_pkg::FN_W'(i);
            page_mapped[page]   = 1'b1;
            x.no_frame          = 1'b0;
            break;
          end
        end
      end
      if (!x.no_frame) begin
        frame   = 32'(frame_of_page[page]);
        x.frame = pta_pkg::FN_W'(frame);
        x.phys  = pta_pkg::PA_W'(((frame << pta_pkg::OFFSET_BITS) | offs))
                  & pta_pkg::PA_MASK;
      end
      owed_xlate_q.push_back(x);
    endfunction

    // Compare one result word with the oldest owed translation
    function void check_result(xlate_t got);
      xlate_t exp_x;
      if (owed_xlate_q.size() == 0) begin
        $error("unexpected result word: phys %h page %h", got.phys, got.page);
        errors++;
        return;
      end
      exp_x = owed_xlate_q.pop_front();
      if (got.phys !== exp_x.phys) begin
        $error("physical_address: expected %h, got %h", exp_x.phys, got.phys);
        errors++;
      end
      if (got.page !== exp_x.page) begin
        $error("page_number: expected %h, got %h", exp_x.page, got.page);
        errors++;
      end
      if (got.frame !== exp_x.frame) begin
        $error("frame_number: expected %h, got %h", exp_x.frame, got.frame);
        errors++;
      end
      if (got.fault !== exp_x.fault) begin
        $error("page_fault: expected %b, got %b", exp_x.fault, got.fault);
        errors++;
      end
      if (got.no_frame !== exp_x.no_frame) begin
        $error("out_of_frames: expected %b, got %b", exp_x.no_frame, got.no_frame);
        errors++;
      end
    endfunction

    function int pending();
      return owed_xlate_q.size();
    endfunction
  endclass

  logic                     clk_i;
  logic                     rst_ni;
  logic                     in_valid_i;
  logic                     in_ready_o;
  logic [pta_pkg::LA_W-1:0] logical_address_i;
  logic                     out_valid_o;
  logic                     out_ready_i;
  logic [pta_pkg::PA_W-1:0] physical_address_o;
  logic [pta_pkg::PN_W-1:0] page_number_o;
  logic [pta_pkg::FN_W-1:0] frame_number_o;
  logic                     page_fault_o;
  logic                     out_of_frames_o;

  xlate_scoreboard          sb = new();
  int                       src_idle_pct = 0;
  int                       snk_idle_pct = 0;
  logic [pta_pkg::PN_W-1:0] touched_pages [$];

  page_translate_alloc dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .logical_address_i  (logical_address_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .physical_address_o (physical_address_o),
    .page_number_o      (page_number_o),
    .frame_number_o     (frame_number_o),
    .page_fault_o       (page_fault_o),
    .out_of_frames_o    (out_of_frames_o)
  );

  // 10 ns clock
  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // Result side: check accepted words, stall at random
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      sb.check_result({physical_address_o, page_number_o, frame_number_o,
                       page_fault_o, out_of_frames_o});
    end
    out_ready_i <= ($urandom_range(99) >= snk_idle_pct);
  end

  // Present one address; valid stays high across back-to-back words
  task automatic send_word(input logic [pta_pkg::LA_W-1:0] la);
    if ($urandom_range(99) < src_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < src_idle_pct);
    end
    in_valid_i        <= 1'b1;
    logical_address_i <= la;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sb.note_address(la);
    touched_pages.push_back(la[pta_pkg::LA_W-1 -: pta_pkg::PN_W]);
  endtask

  // Hold off the sender until every owed word has come back
  task automatic drain_block();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (sb.pending() != 0);
  endtask

  // Mostly revisits of mapped pages with fresh offsets, rest fully random
  task automatic random_phase(input int n_words);
    logic [pta_pkg::LA_W-1:0] la;
    for (int i = 0; i < n_words; i++) begin
      la = pta_pkg::LA_W'($urandom);
      if (touched_pages.size() != 0 && $urandom_range(99) < 55) begin
        la[pta_pkg::LA_W-1 -: pta_pkg::PN_W] =
          touched_pages[$urandom_range(touched_pages.size() - 1)];
      end
      send_word(la);
    end
  endtask

  initial begin
    rst_ni            = 1'b0;
    in_valid_i        = 1'b0;
    logical_address_i = '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: all-zero and all-one addresses, hits with other offsets,
    // page and offset extremes, alternating bit patterns.
    // With as many frames as pages the allocator never runs dry here.
    snk_idle_pct = 30;
    send_word(16'h0000);
    send_word(16'h0000);
    send_word(16'h00FF);
    send_word(16'hFFFF);
    send_word(16'hFF00);
    send_word(16'h0100);
    send_word(16'h01FF);
    send_word(16'h5555);
    send_word(16'hAAAA);
    send_word(16'h55AA);
    send_word(16'hAA55);
    send_word(16'h8000);
    send_word(16'h7FFF);
    send_word(16'h0080);
    send_word(16'hFE01);
    send_word(16'h0201);
    drain_block();

    // Random: receiver-heavy idling, then sender-heavy, then none
    src_idle_pct = 35;
    snk_idle_pct = 51;
    random_phase(420);
    drain_block();
    src_idle_pct = 51;
    snk_idle_pct = 35;
    random_phase(420);
    drain_block();
    src_idle_pct = 0;
    snk_idle_pct = 0;
    random_phase(420);

    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("tb_page_translate_alloc: PASS");
    end else begin
      $display("tb_page_translate_alloc: FAIL");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2_000_000;
    $display("tb_page_translate_alloc: FAIL");
    $finish;
  end

endmodule

// File: sim.f
rtl/pta_pkg.sv
rtl/pta_ctrl.sv
rtl/pta_dp.sv
rtl/page_translate_alloc.sv
dv/tb_page_translate_alloc.sv
